// ----- rtl/lrd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the line rasteriser.
package lrd_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ClipBits  = 11;
  localparam int unsigned CmpBits   = CoordBits + ClipBits;

  localparam logic [ClipBits-1:0] ClipReset = ClipBits'(600);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CLIP_WIDTH  = 1'b0;
  localparam logic CFG_CLIP_HEIGHT = 1'b1;

  typedef struct packed {
    logic capture;  // latch endpoints, pick major axis
    logic order;    // order endpoints, set up accumulator
    logic step;     // emit one pixel and advance
  } cmd_t;

  typedef struct packed {
    logic fin;      // current pixel is the last of the line
  } stat_t;

  // Magnitude of b - a, always fits CoordBits unsigned bits.
  function automatic logic [CoordBits-1:0] abs_diff(logic signed [CoordBits-1:0] a,
                                                    logic signed [CoordBits-1:0] b);
    logic signed [DiffBits-1:0] d;
    logic signed [DiffBits-1:0] m;
    d = DiffBits'(b) - DiffBits'(a);
    m = d[DiffBits-1] ? -d : d;
    return m[CoordBits-1:0];
  endfunction

endpackage

// ----- rtl/lrd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the line rasteriser.
module lrd_ctrl import lrd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  input  logic  command_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StOrder = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign busy = (state_q == StOrder);
  assign take = start && !busy;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.order   = 1'b0;
    cmd_o.step    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (take && command_i == CMD_LOAD) begin
          cmd_o.capture = 1'b1;
          state_d       = StOrder;
        end
      end
      StOrder: begin
        cmd_o.order = 1'b1;
        state_d     = StRun;
      end
      StRun: begin
        if (take && command_i == CMD_LOAD) begin
          cmd_o.capture = 1'b1;
          state_d       = StOrder;
        end else if (take) begin
          cmd_o.step = 1'b1;
          if (stat_i.fin) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lrd_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the line rasteriser: endpoints, accumulator, clip and pixel output.
module lrd_datapath import lrd_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output stat_t                       stat_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ClipBits-1:0]         cfg_wdata_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  output logic                        pixel_valid_o,
  output logic signed [CoordBits-1:0] pixel_x_o,
  output logic signed [CoordBits-1:0] pixel_y_o,
  output logic                        inside_res_o,
  output logic                        last_o
);

  logic [ClipBits-1:0] clip_w_q, clip_h_q;

  logic signed [CoordBits-1:0] sx_q, sy_q, ex_q, ey_q;
  logic                        x_major_q;

  logic signed [CoordBits-1:0] major_pos_q, major_end_q;
  logic signed [CoordBits-1:0] minor_cur_q;
  logic [CoordBits-1:0]        span_q, delta_q, acc_q;
  logic                        neg_q;

  logic                        valid_q;
  logic signed [CoordBits-1:0] px_q, py_q;
  logic                        ins_q, last_q;

  // Ordering
  logic signed [CoordBits-1:0] a0, a1, b0, b1;
  logic signed [DiffBits-1:0]  d_raw;
  logic                        swap;

  // Stepping
  logic signed [CoordBits-1:0] minor_val, px, py;
  logic [CoordBits:0]          acc_sum;
  logic                        acc_wrap, px_in, py_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_w_q <= ClipReset;
      clip_h_q <= ClipReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLIP_WIDTH:  clip_w_q <= cfg_wdata_i;
        CFG_CLIP_HEIGHT: clip_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign a0    = x_major_q ? sx_q : sy_q;
  assign a1    = x_major_q ? ex_q : ey_q;
  assign swap  = a0 > a1;
  assign b0    = x_major_q ? (swap ? ey_q : sy_q) : (swap ? ex_q : sx_q);
  assign b1    = x_major_q ? ey_q : ex_q;
  assign d_raw = DiffBits'(b1) - DiffBits'(x_major_q ? sy_q : sx_q);

  assign stat_o.fin = major_pos_q >= major_end_q;

  // Truncate toward zero when a fraction is pending
  always_comb begin
    minor_val = minor_cur_q;
    if (acc_q != '0) begin
      if (!neg_q && minor_cur_q < 0)      minor_val = minor_cur_q + CoordBits'(1);
      else if (neg_q && minor_cur_q > 0)  minor_val = minor_cur_q - CoordBits'(1);
    end
  end

  assign px    = x_major_q ? major_pos_q : minor_val;
  assign py    = x_major_q ? minor_val : major_pos_q;
  assign px_in = !px[CoordBits-1] && (px != '0) &&
                 (CmpBits'($unsigned(px)) < CmpBits'(clip_w_q));
  assign py_in = !py[CoordBits-1] && (py != '0) &&
                 (CmpBits'($unsigned(py)) < CmpBits'(clip_h_q));

  assign acc_sum  = {1'b0, acc_q} + {1'b0, delta_q};
  assign acc_wrap = acc_sum >= {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sx_q      <= start_x_i;
      sy_q      <= start_y_i;
      ex_q      <= end_x_i;
      ey_q      <= end_y_i;
      x_major_q <= abs_diff(start_x_i, end_x_i) > abs_diff(start_y_i, end_y_i);
    end
    if (cmd_i.order) begin
      major_pos_q <= swap ? a1 : a0;
      major_end_q <= swap ? a0 : a1;
      span_q      <= swap ? abs_diff(a1, a0) : abs_diff(a0, a1);
      minor_cur_q <= b0;
      delta_q     <= abs_diff(x_major_q ? sy_q : sx_q, b1);
      neg_q       <= swap ? (d_raw > 0) : (d_raw < 0);
      acc_q       <= '0;
    end else if (cmd_i.step && !stat_o.fin) begin
      major_pos_q <= major_pos_q + CoordBits'(1);
      if (acc_wrap) begin
        acc_q       <= CoordBits'(acc_sum - {1'b0, span_q});
        minor_cur_q <= neg_q ? minor_cur_q - CoordBits'(1) : minor_cur_q + CoordBits'(1);
      end else begin
        acc_q <= acc_sum[CoordBits-1:0];
      end
    end
    if (cmd_i.step) begin
      px_q   <= px;
      py_q   <= py;
      ins_q  <= px_in && py_in;
      last_q <= stat_o.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.step;
    end
  end

  assign pixel_valid_o = valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign inside_res_o  = ins_q;
  assign last_o        = last_q;

endmodule

// ----- rtl/line_rasterizer_dda.sv -----
`timescale 1ns / 1ps
// Top level of the DDA line rasteriser: controller plus datapath.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   command   | start / busy         | command_i, start_x_i, start_y_i, end_x_i, end_y_i
//   pixel     | pixel_valid_o strobe | pixel_x_o, pixel_y_o, inside_res_o, last_o
//   config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// A step transaction's pixel appears on the outputs in the cycle after acceptance, for
// exactly one cycle, and the next step may be accepted straight away.
// During a load transaction busy is high for the cycle in which the
// endpoints are ordered and the accumulator set up.
// The per-pixel cost is one add and one conditional subtract in the remainder loop.
// Reset (rst_ni low) drops any line in progress and sets both clip registers to 600.
// The receiver cannot stall; a pixel not taken in its cycle is gone.
module line_rasterizer_dda import lrd_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [ClipBits-1:0]         cfg_wdata_i,
  output logic                        pixel_valid_o,
  output logic signed [CoordBits-1:0] pixel_x_o,
  output logic signed [CoordBits-1:0] pixel_y_o,
  output logic                        inside_res_o,
  output logic                        last_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence loads and steps; hold the line-active state
  lrd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Advance the major coordinate and the remainder accumulator, register each pixel
  lrd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_valid_o (pixel_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .inside_res_o  (inside_res_o),
    .last_o        (last_o)
  );

endmodule
